// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl that carries checks
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/chm_pkg.sv -----
// shared types and constants of the cache hit/miss model
// no dependencies; imported by every module of the block
`default_nettype none

package chm_pkg;

    localparam int LINES_DEFAULT = 1024;
    localparam int WAYS          = 4;
    localparam int WAY_W         = 2;
    localparam int ADDR_W        = 32;
    localparam int TAG_W         = 32;
    localparam int SET_W         = 10;
    localparam int CNT_W         = 32;

    localparam logic [3:0] MAX_OFFSET       = 4'd12;
    localparam logic [3:0] MAX_INDEX_DIRECT = 4'd10;
    localparam logic [3:0] MAX_INDEX_ASSOC  = 4'd8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ASSOC_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd2;

    localparam logic [3:0] OFFSET_BITS_RESET = 4'd5;
    localparam logic [3:0] INDEX_BITS_RESET  = 4'd5;

    // one set of the tag memory: fifo pointer, valid bits and tags of four ways
    typedef struct packed {
        logic [WAY_W-1:0]            fifo;
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0][TAG_W-1:0]  tag;
    } row_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // capture the incoming transaction
        logic lookup;   // reduce set to a row and read the tag memory
        logic update;   // compare, write back, bump counters, load result
        logic clear;    // write a zero row during the post-reset sweep
    } cmd_t;

endpackage

`default_nettype wire

// ----- sv/cache_hit_miss_model.sv -----
// cache hit/miss model: one access in, one hit/miss result with counts out
// usage:
//   input transaction (in_valid/in_ready): req_type (0 read, 1 write) and
//   a 32-bit address. result transaction (out_valid/out_ready): hit, way
//   used and the saturating hit, miss, memory read and memory write totals.
//   config writes (cfg_we, cfg_index, cfg_wdata) take effect at once; the user
//   must issue them only while no access is in flight; the block has no guard for it.
// timing:
//   an access runs as capture and address split, set reduction and
//   tag memory read, then compare and write-back. the registered tag row
//   read-modify-write sets this, so one access is in flight at a time and a
//   new one is taken once the last is written back; out_valid is registered.
// reset:
//   counters and config return to defaults; the tag memory is then swept
//   clear, one row a cycle, LINES/4 rows (256 at the default size), with
//   in_ready low. config writes are still taken during the sweep.
// stall:
//   a held result keeps its value; the next access is taken and looked up,
//   and waits in its compare stage until the result register frees up
`default_nettype none
`include "assert_macros.svh"

module cache_hit_miss_model #(
    parameter int LINES = chm_pkg::LINES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [chm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [chm_pkg::ADDR_W-1:0]         address,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic [chm_pkg::WAY_W-1:0]          way_used,
    output logic [chm_pkg::CNT_W-1:0]          hit_total,
    output logic [chm_pkg::CNT_W-1:0]          miss_total,
    output logic [chm_pkg::CNT_W-1:0]          mem_read_total,
    output logic [chm_pkg::CNT_W-1:0]          mem_write_total
);
    import chm_pkg::*;

    // one tag memory row per set of four ways
    localparam int ROWS  = LINES / WAYS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    cmd_t             cmd;
    logic [ROW_W-1:0] clr_row;

    // sequencing: clear sweep, capture, lookup, update
    chm_ctrl #(
        .LINES (LINES),
        .ROW_W (ROW_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .clr_row   (clr_row)
    );

    // address split, tag store, replacement and counters
    chm_datapath #(
        .LINES (LINES),
        .ROW_W (ROW_W)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .clr_row         (clr_row),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .req_type        (req_type),
        .address         (address),
        .hit             (hit),
        .way_used        (way_used),
        .hit_total       (hit_total),
        .miss_total      (miss_total),
        .mem_read_total  (mem_read_total),
        .mem_write_total (mem_write_total)
    );

    // one access in flight: no second accept right after the first
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    // the tag memory read follows every accept
    `ASSERT_NEXT(a_lookup_follows, clk, rst_n, in_valid && in_ready, cmd.lookup)
    // a new result only appears after an update
    `ASSERT_SAME(a_result_from_update, clk, rst_n, $rose(out_valid), $past(cmd.update))
    // no access is taken while the tag memory is being cleared
    `ASSERT_ALWAYS(a_no_accept_in_clear, clk, rst_n, !(cmd.clear && in_ready))

endmodule

`default_nettype wire

// ----- sv/chm_ctrl.sv -----
// controller state machine of the cache hit/miss model
// depends on chm_pkg; drives commands into chm_datapath
`default_nettype none

module chm_ctrl #(
    parameter int LINES = chm_pkg::LINES_DEFAULT,
    parameter int ROW_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output chm_pkg::cmd_t      cmd,
    output logic [ROW_W-1:0]   clr_row
);
    import chm_pkg::*;

    localparam int ROWS = LINES / WAYS;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_ADDR  = 4'b0100,
        ST_LOOK  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [ROW_W-1:0] clr_reg, clr_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (clr_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + ROW_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                // hold the compare and update until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign clr_row   = clr_reg;

endmodule

`default_nettype wire

// ----- sv/chm_tag_ram.sv -----
// tag memory: one row per set holding tags, valid bits and fifo pointer
// depends on chm_pkg for the row layout; one write and one read port
`default_nettype none

module chm_tag_ram #(
    parameter int ROWS  = chm_pkg::LINES_DEFAULT / chm_pkg::WAYS,
    parameter int ROW_W = 8
) (
    input  logic               clk,
    input  logic               we,
    input  logic [ROW_W-1:0]   waddr,
    input  chm_pkg::row_t      wdata,
    input  logic               re,
    input  logic [ROW_W-1:0]   raddr,
    output chm_pkg::row_t      rdata
);
    import chm_pkg::*;

    row_t mem [ROWS];
    row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/chm_datapath.sv -----
// datapath: config registers, address split, set reduction, tag compare,
// replacement and counters; depends on chm_pkg and chm_tag_ram
`default_nettype none

module chm_datapath #(
    parameter int LINES = chm_pkg::LINES_DEFAULT,
    parameter int ROW_W = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  chm_pkg::cmd_t                      cmd,
    input  logic [ROW_W-1:0]                   clr_row,
    input  logic                               cfg_we,
    input  logic [chm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               req_type,
    input  logic [chm_pkg::ADDR_W-1:0]         address,
    output logic                               hit,
    output logic [chm_pkg::WAY_W-1:0]          way_used,
    output logic [chm_pkg::CNT_W-1:0]          hit_total,
    output logic [chm_pkg::CNT_W-1:0]          miss_total,
    output logic [chm_pkg::CNT_W-1:0]          mem_read_total,
    output logic [chm_pkg::CNT_W-1:0]          mem_write_total
);
    import chm_pkg::*;

    localparam int ROWS   = LINES / WAYS;
    localparam int LW     = ROW_W + WAY_W;
    localparam int MW     = (LW > SET_W) ? LW : SET_W;
    localparam int QSTEPS = 8;   // quotient of a 10-bit set by 4 or more fits 8 bits

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

    // configuration registers
    logic       assoc_mode_reg;
    logic [3:0] offset_bits_reg;
    logic [3:0] index_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assoc_mode_reg  <= 1'b0;
            offset_bits_reg <= OFFSET_BITS_RESET;
            index_bits_reg  <= INDEX_BITS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ASSOC_MODE:  assoc_mode_reg  <= cfg_wdata[0];
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata;
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // address split of the incoming transaction
    logic [3:0]        ob, ib, ib_max;
    logic [4:0]        tag_shift;
    logic [ADDR_W-1:0] shifted;
    logic [SET_W:0]    set_mask;
    logic [SET_W-1:0]  set_c;
    logic [TAG_W-1:0]  tag_c;

    always_comb
    begin
        ob        = (offset_bits_reg > MAX_OFFSET) ? MAX_OFFSET : offset_bits_reg;
        ib_max    = assoc_mode_reg ? MAX_INDEX_ASSOC : MAX_INDEX_DIRECT;
        ib        = (index_bits_reg > ib_max) ? ib_max : index_bits_reg;
        shifted   = address >> ob;
        set_mask  = ((SET_W + 1)'(1) << ib) - (SET_W + 1)'(1);
        set_c     = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_shift = {1'b0, ob} + {1'b0, ib};
        tag_c     = address >> tag_shift;
    end

    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             write_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            set_reg   <= set_c;
            tag_reg   <= tag_c;
            write_reg <= req_type;
        end
    end

    // set reduction modulo the number of lines or sets, by restoring steps
    logic [MW-1:0]    rem_d, rem_a;
    logic [ROW_W-1:0] row_sel;
    logic [WAY_W-1:0] dway_sel;

    always_comb
    begin
        rem_d = MW'(set_reg);
        rem_a = MW'(set_reg);
        for (int k = QSTEPS - 1; k >= 0; k--)
        begin
            if (32'(rem_d) >= (32'(LINES) << k))
            begin
                rem_d = rem_d - MW'(32'(LINES) << k);
            end
            if (32'(rem_a) >= (32'(ROWS) << k))
            begin
                rem_a = rem_a - MW'(32'(ROWS) << k);
            end
        end
        if (assoc_mode_reg)
        begin
            row_sel  = rem_a[ROW_W-1:0];
            dway_sel = '0;
        end
        else
        begin
            // direct mode: line splits into row and way within the row
            row_sel  = rem_d[LW-1:WAY_W];
            dway_sel = rem_d[WAY_W-1:0];
        end
    end

    logic [ROW_W-1:0] row_reg;
    logic [WAY_W-1:0] dway_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            row_reg  <= row_sel;
            dway_reg <= dway_sel;
        end
    end

    // tag memory
    row_t             rd_row, new_row, wr_row;
    logic             ram_we;
    logic [ROW_W-1:0] ram_waddr;

    chm_tag_ram #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_row),
        .re    (cmd.lookup),
        .raddr (row_sel),
        .rdata (rd_row)
    );

    // compare and replacement
    logic [WAYS-1:0]  match;
    logic [WAY_W-1:0] hit_way, free_way, fill_way, way_c;
    logic             any_free, hit_c;

    always_comb
    begin
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            match[w] = rd_row.valid[w] && (rd_row.tag[w] == tag_reg);
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!rd_row.valid[w])
            begin
                free_way = WAY_W'(w);
            end
        end
        any_free = ~&rd_row.valid;
        new_row  = rd_row;
        if (!assoc_mode_reg)
        begin
            hit_c    = match[dway_reg];
            way_c    = '0;
            fill_way = dway_reg;
        end
        else
        begin
            hit_c = |match;
            if (hit_c)
            begin
                way_c = hit_way;
            end
            else if (any_free)
            begin
                way_c = free_way;
            end
            else
            begin
                // all ways valid: evict in fifo order
                way_c        = rd_row.fifo;
                new_row.fifo = rd_row.fifo + WAY_W'(1);
            end
            fill_way = way_c;
        end
        new_row.valid[fill_way] = 1'b1;
        new_row.tag[fill_way]   = tag_reg;

        ram_we    = cmd.clear || (cmd.update && !hit_c);
        ram_waddr = cmd.clear ? clr_row : row_reg;
        wr_row    = cmd.clear ? '0 : new_row;
    end

    // result and running counts
    logic             hit_reg;
    logic [WAY_W-1:0] way_reg;
    logic [CNT_W-1:0] hit_cnt_reg, miss_cnt_reg, read_cnt_reg, write_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_reg <= hit_c;
            way_reg <= way_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            read_cnt_reg  <= '0;
            write_cnt_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (write_reg)
            begin
                write_cnt_reg <= sat_inc(write_cnt_reg);
            end
            if (hit_c)
            begin
                hit_cnt_reg <= sat_inc(hit_cnt_reg);
            end
            else
            begin
                miss_cnt_reg <= sat_inc(miss_cnt_reg);
                read_cnt_reg <= sat_inc(read_cnt_reg);
            end
        end
    end

    assign hit             = hit_reg;
    assign way_used        = way_reg;
    assign hit_total       = hit_cnt_reg;
    assign miss_total      = miss_cnt_reg;
    assign mem_read_total  = read_cnt_reg;
    assign mem_write_total = write_cnt_reg;

endmodule

`default_nettype wire
